// ===== sv/sti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table package
// Shared codes and the command and status structures that pass between the
// sorted table controller and its datapath.
// ----------------------------------------------------------------------------
package sti_pkg;

	localparam int unsigned FUNC_W     = 2;
	localparam int unsigned VALUE_IN_W = 16;
	localparam int unsigned INDEX_W    = 6;
	localparam int unsigned COUNT_OUT_W = 7;
	localparam int unsigned CAP_W      = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_BADINDEX = 2'd3
	} status_t;

	typedef struct packed {
		logic    latch;
		logic    ins_begin;
		logic    ins_shift;
		logic    ins_above;
		logic    ins_zero;
		logic    rem_begin;
		logic    rem_step;
		logic    rd_begin;
		logic    sel_rdata;
		logic    finish;
		status_t status;
	} cmd_t;

	typedef struct packed {
		logic is_ins;
		logic is_rem;
		logic is_rd;
		logic empty;
		logic full;
		logic idx_bad;
		logic gt;
		logic ptr_zero;
		logic ptr_last;
		logic none_removed;
	} flags_t;

endpackage

// ===== sv/sorted_table_insert_remove.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table with insert, remove and read
// Keeps up to DEPTH unsigned values in ascending order at the front of a
// single-port-write memory, with a capacity register.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result is
// shown for exactly one cycle with done high and cannot be held off, so the
// receiver must take it then. One transaction is worked on at a time, set by
// the single memory read port that the scan walks one entry per cycle. A new
// start may be given in the cycle that done is shown.
module sorted_table_insert_remove #(
	parameter int unsigned DEPTH       = 64,
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [sti_pkg::FUNC_W-1:0]           func,
	input  logic [sti_pkg::VALUE_IN_W-1:0]       value,
	input  logic [sti_pkg::INDEX_W-1:0]          index,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic [sti_pkg::VALUE_IN_W-1:0]       read_value,
	output logic [sti_pkg::COUNT_OUT_W-1:0]      entry_count,
	output logic [sti_pkg::COUNT_OUT_W-1:0]      removed_count,
	input  logic                                 cfg_wr_en,
	input  logic [sti_pkg::CAP_W-1:0]            cfg_wr_data
);
	import sti_pkg::*;

	cmd_t   cmd;
	flags_t flags;

	sti_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.cmd    (cmd),
		.busy   (busy)
	);

	sti_dpath #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.func          (func),
		.value         (value),
		.index         (index),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.cmd           (cmd),
		.flags         (flags),
		.done          (done),
		.status        (status),
		.read_value    (read_value),
		.entry_count   (entry_count),
		.removed_count (removed_count)
	);

endmodule

// ===== sv/sti_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table datapath
// Table memory with one write and one registered read port, the entry count,
// the capacity register, the scan pointers and the result registers.
// ----------------------------------------------------------------------------
module sti_dpath #(
	parameter int unsigned DEPTH       = 64,
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [sti_pkg::FUNC_W-1:0]           func,
	input  logic [sti_pkg::VALUE_IN_W-1:0]       value,
	input  logic [sti_pkg::INDEX_W-1:0]          index,
	input  logic                                 cfg_wr_en,
	input  logic [sti_pkg::CAP_W-1:0]            cfg_wr_data,
	input  sti_pkg::cmd_t                        cmd,
	output sti_pkg::flags_t                      flags,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic [sti_pkg::VALUE_IN_W-1:0]       read_value,
	output logic [sti_pkg::COUNT_OUT_W-1:0]      entry_count,
	output logic [sti_pkg::COUNT_OUT_W-1:0]      removed_count
);
	import sti_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned EW = (CW > CAP_W) ? CW : CAP_W;
	localparam int unsigned IW = (CW > INDEX_W) ? CW : INDEX_W;

	logic [VALUE_WIDTH-1:0] mem [DEPTH];
	logic [VALUE_WIDTH-1:0] rdata_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [FUNC_W-1:0]      func_q;
	logic [INDEX_W-1:0]     idx_q;
	logic [AW-1:0]          ptr_q;
	logic [CW-1:0]          wr_q;
	logic [CW-1:0]          count_q;
	logic [CAP_W-1:0]       cap_q;
	logic                   done_q;
	status_t                status_q;
	logic [VALUE_IN_W-1:0]  read_value_q;
	logic [COUNT_OUT_W-1:0] entry_count_q;
	logic [COUNT_OUT_W-1:0] removed_q;

	logic                   we;
	logic [AW-1:0]          waddr;
	logic [VALUE_WIDTH-1:0] wdata;
	logic                   re;
	logic [AW-1:0]          raddr;
	logic [AW-1:0]          ptr_next;
	logic                   keep;
	logic [CW-1:0]          rem_count;
	logic [CW-1:0]          count_m1;
	logic [CW-1:0]          count_next;

	assign keep      = (rdata_q != val_q);
	assign rem_count = wr_q + CW'(keep);
	assign count_m1  = count_q - CW'(1);

	always_comb begin
		we       = 1'b0;
		waddr    = '0;
		wdata    = rdata_q;
		re       = 1'b0;
		raddr    = '0;
		ptr_next = ptr_q;
		if (cmd.ins_begin) begin
			re       = 1'b1;
			raddr    = AW'(count_m1);
			ptr_next = AW'(count_m1);
		end
		if (cmd.ins_shift) begin
			we       = 1'b1;
			waddr    = ptr_q + AW'(1);
			wdata    = rdata_q;
			re       = 1'b1;
			raddr    = ptr_q - AW'(1);
			ptr_next = ptr_q - AW'(1);
		end
		if (cmd.ins_above) begin
			we    = 1'b1;
			waddr = ptr_q + AW'(1);
			wdata = val_q;
		end
		if (cmd.ins_zero) begin
			we    = 1'b1;
			waddr = '0;
			wdata = val_q;
		end
		if (cmd.rem_begin) begin
			re       = 1'b1;
			raddr    = '0;
			ptr_next = '0;
		end
		if (cmd.rem_step) begin
			we       = keep;
			waddr    = AW'(wr_q);
			wdata    = rdata_q;
			re       = 1'b1;
			raddr    = ptr_q + AW'(1);
			ptr_next = ptr_q + AW'(1);
		end
		if (cmd.rd_begin) begin
			re    = 1'b1;
			raddr = AW'(idx_q);
		end
	end

	always_comb begin
		count_next = count_q;
		if (cmd.ins_above || cmd.ins_zero) begin
			count_next = count_q + CW'(1);
		end else if (cmd.rem_step && cmd.finish) begin
			count_next = rem_count;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_next;
		if (cmd.latch) begin
			func_q <= func;
			val_q  <= VALUE_WIDTH'(value);
			idx_q  <= index;
		end
		if (cmd.rem_begin) begin
			wr_q <= '0;
		end else if (cmd.rem_step) begin
			wr_q <= rem_count;
		end
		if (cmd.finish) begin
			status_q      <= cmd.status;
			read_value_q  <= cmd.sel_rdata ? VALUE_IN_W'(rdata_q) : '0;
			entry_count_q <= COUNT_OUT_W'(count_next);
			removed_q     <= cmd.rem_step ? COUNT_OUT_W'(count_q - rem_count) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= cmd.finish;
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
		end
	end

	assign flags.is_ins       = (func_q == FN_INSERT);
	assign flags.is_rem       = (func_q == FN_REMOVE);
	assign flags.is_rd        = (func_q == FN_READ);
	assign flags.empty        = (count_q == '0);
	assign flags.full         = (EW'(count_q) >= EW'(cap_q)) || (count_q == CW'(DEPTH));
	assign flags.idx_bad      = (IW'(idx_q) >= IW'(count_q));
	assign flags.gt           = (rdata_q > val_q);
	assign flags.ptr_zero     = (ptr_q == '0);
	assign flags.ptr_last     = (ptr_q == AW'(count_m1));
	assign flags.none_removed = (rem_count == count_q);

	assign done          = done_q;
	assign status        = status_q;
	assign read_value    = read_value_q;
	assign entry_count   = entry_count_q;
	assign removed_count = removed_q;

endmodule

// ===== sv/sti_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table controller
// State machine that sequences insert shifts, remove compaction and reads
// over the table datapath.
// ----------------------------------------------------------------------------
module sti_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  sti_pkg::flags_t flags,
	output sti_pkg::cmd_t   cmd,
	output logic            busy
);
	import sti_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_DISPATCH = 6'b000010,
		S_INS      = 6'b000100,
		S_INS_ZERO = 6'b001000,
		S_REM      = 6'b010000,
		S_RD       = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_next;

	always_comb begin
		cmd        = '0;
		cmd.status = ST_OK;
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch  = 1'b1;
					state_next = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_next = S_IDLE;
				if (flags.is_ins) begin
					if (flags.full) begin
						cmd.finish = 1'b1;
						cmd.status = ST_FULL;
					end else if (flags.empty) begin
						cmd.ins_zero = 1'b1;
						cmd.finish   = 1'b1;
					end else begin
						cmd.ins_begin = 1'b1;
						state_next    = S_INS;
					end
				end else if (flags.is_rem) begin
					if (flags.empty) begin
						cmd.finish = 1'b1;
						cmd.status = ST_NOTFOUND;
					end else begin
						cmd.rem_begin = 1'b1;
						state_next    = S_REM;
					end
				end else if (flags.is_rd) begin
					if (flags.idx_bad) begin
						cmd.finish = 1'b1;
						cmd.status = ST_BADINDEX;
					end else begin
						cmd.rd_begin = 1'b1;
						state_next   = S_RD;
					end
				end else begin
					cmd.finish = 1'b1;
				end
			end
			S_INS: begin
				if (flags.gt) begin
					cmd.ins_shift = 1'b1;
					if (flags.ptr_zero) begin
						state_next = S_INS_ZERO;
					end
				end else begin
					cmd.ins_above = 1'b1;
					cmd.finish    = 1'b1;
					state_next    = S_IDLE;
				end
			end
			S_INS_ZERO: begin
				cmd.ins_zero = 1'b1;
				cmd.finish   = 1'b1;
				state_next   = S_IDLE;
			end
			S_REM: begin
				cmd.rem_step = 1'b1;
				if (flags.ptr_last) begin
					cmd.finish = 1'b1;
					cmd.status = flags.none_removed ? ST_NOTFOUND : ST_OK;
					state_next = S_IDLE;
				end
			end
			S_RD: begin
				cmd.sel_rdata = 1'b1;
				cmd.finish    = 1'b1;
				state_next    = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== verif/tb_sorted_table_insert_remove.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sorted table with insert, remove and read
// Drives insert, remove, read and unused commands through the start and busy
// handshake under several capacity settings and predicts every result from a
// private copy of the table. Each transaction's result is compared field by
// field as it is strobed out.
// ----------------------------------------------------------------------------
module tb_sorted_table_insert_remove;
	import sti_pkg::*;

	localparam int unsigned TABLE_DEPTH = 64;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned DRAIN_CYCLES = 80;
	localparam int unsigned NUM_PHASES = 12;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	typedef struct {
		status_t                status;
		logic [VALUE_IN_W-1:0]  read_value;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic [COUNT_OUT_W-1:0] removed_count;
	} table_outcome_t;

	class table_scoreboard;
		logic [VALUE_IN_W-1:0] entries [TABLE_DEPTH];
		int unsigned count;
		int unsigned capacity;
		table_outcome_t outcomes [$];
		int unsigned errors;

		function new();
			count = 0;
			capacity = 32'(CAP_RESET);
			errors = 0;
		endfunction

		function void note_command(input logic [FUNC_W-1:0] f, input logic [VALUE_IN_W-1:0] v,
				input logic [INDEX_W-1:0] idx);
			table_outcome_t o;
			int unsigned pos;
			int unsigned k;
			int unsigned wr;
			int unsigned eff_cap;
			o.status = ST_OK;
			o.read_value = '0;
			o.removed_count = '0;
			case (f)
				FN_INSERT: begin
					eff_cap = (capacity > TABLE_DEPTH) ? TABLE_DEPTH : capacity;
					if (count >= eff_cap || count >= TABLE_DEPTH) begin
						o.status = ST_FULL;
					end else begin
						pos = 0;
						while (pos < count && entries[pos] <= v)
							pos++;
						for (k = count; k > pos; k--)
							entries[k] = entries[k-1];
						entries[pos] = v;
						count++;
					end
				end
				FN_REMOVE: begin
					wr = 0;
					for (k = 0; k < count; k++) begin
						if (entries[k] != v) begin
							entries[wr] = entries[k];
							wr++;
						end
					end
					o.removed_count = COUNT_OUT_W'(count - wr);
					count = wr;
					if (o.removed_count == 0)
						o.status = ST_NOTFOUND;
				end
				FN_READ: begin
					if (idx < count)
						o.read_value = entries[idx];
					else
						o.status = ST_BADINDEX;
				end
				default: begin
				end
			endcase
			o.entry_count = COUNT_OUT_W'(count);
			outcomes.push_back(o);
		endfunction

		function void check_outcome(input logic [1:0] st, input logic [VALUE_IN_W-1:0] rv,
				input logic [COUNT_OUT_W-1:0] ec, input logic [COUNT_OUT_W-1:0] rc);
			table_outcome_t o;
			if (outcomes.size() == 0) begin
				$display("%0t: result with no transaction pending, status %0d entry_count %0d",
					$time, st, ec);
				errors++;
				return;
			end
			o = outcomes.pop_front();
			if (st !== o.status) begin
				$display("%0t: status expected %0d actual %0d", $time, o.status, st);
				errors++;
			end
			if (rv !== o.read_value) begin
				$display("%0t: read_value expected %0h actual %0h", $time, o.read_value, rv);
				errors++;
			end
			if (ec !== o.entry_count) begin
				$display("%0t: entry_count expected %0d actual %0d", $time, o.entry_count, ec);
				errors++;
			end
			if (rc !== o.removed_count) begin
				$display("%0t: removed_count expected %0d actual %0d", $time,
					o.removed_count, rc);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [FUNC_W-1:0]      func;
	logic [VALUE_IN_W-1:0]  value;
	logic [INDEX_W-1:0]     index;
	logic                   done;
	logic [1:0]             status;
	logic [VALUE_IN_W-1:0]  read_value;
	logic [COUNT_OUT_W-1:0] entry_count;
	logic [COUNT_OUT_W-1:0] removed_count;
	logic                   cfg_wr_en;
	logic [CAP_W-1:0]       cfg_wr_data;

	table_scoreboard sb = new();
	int unsigned cycle_count = 0;

	int unsigned phase_cap [NUM_PHASES] = '{127, 5, 0, 64, 1, 37, 64, 100, 2, 64, 20, 63};
	int unsigned phase_len [NUM_PHASES] = '{150, 150, 100, 200, 150, 150, 150, 150, 150,
		150, 150, 120};
	int unsigned phase_ins [NUM_PHASES] = '{90, 40, 40, 60, 50, 65, 85, 45, 50, 70, 50, 55};
	int unsigned phase_rem [NUM_PHASES] = '{3, 30, 30, 15, 25, 15, 5, 30, 25, 10, 25, 20};

	sorted_table_insert_remove dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.value        (value),
		.index        (index),
		.done         (done),
		.status       (status),
		.read_value   (read_value),
		.entry_count  (entry_count),
		.removed_count(removed_count),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (done === 1'b1)
			sb.check_outcome(status, read_value, entry_count, removed_count);
	end

	function automatic logic [VALUE_IN_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4, 5: return VALUE_IN_W'($urandom_range(0, 7));
			default: return VALUE_IN_W'($urandom);
		endcase
	endfunction

	task automatic issue(input logic [FUNC_W-1:0] f, input logic [VALUE_IN_W-1:0] v,
			input logic [INDEX_W-1:0] idx);
		start <= 1'b1;
		func <= f;
		value <= v;
		index <= idx;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_command(f, v, idx);
	endtask

	task automatic sender_gap(input int unsigned pct);
		while ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			func <= FUNC_W'($urandom);
			value <= VALUE_IN_W'($urandom);
			index <= INDEX_W'($urandom);
			@(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (sb.outcomes.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] c);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= c;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.capacity = 32'(c);
	endtask

	initial begin : stimulus
		int unsigned p;
		int unsigned n;
		int unsigned r;
		int unsigned pct;
		logic [FUNC_W-1:0] f;
		logic [VALUE_IN_W-1:0] v;
		logic [INDEX_W-1:0] idx;

		arst_n <= 1'b0;
		start <= 1'b0;
		func <= '0;
		value <= '0;
		index <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(FN_READ, 16'h0000, 6'd0);
		issue(FN_REMOVE, 16'h1234, 6'd0);
		issue(FN_UNUSED, 16'h0000, 6'd0);
		issue(FN_INSERT, 16'hFFFF, 6'd0);
		issue(FN_INSERT, 16'h0000, 6'd0);
		issue(FN_INSERT, 16'h8000, 6'd0);
		issue(FN_INSERT, 16'h8000, 6'd0);
		issue(FN_INSERT, 16'h8000, 6'd0);
		issue(FN_READ, 16'h0000, 6'd0);
		issue(FN_READ, 16'h0000, 6'd2);
		issue(FN_READ, 16'h0000, 6'd4);
		issue(FN_READ, 16'h0000, 6'd5);
		issue(FN_READ, 16'hFFFF, 6'd63);
		issue(FN_REMOVE, 16'h8000, 6'd0);
		issue(FN_REMOVE, 16'h8000, 6'd0);
		issue(FN_READ, 16'h0000, 6'd1);
		issue(FN_UNUSED, 16'hFFFF, 6'd63);
		write_capacity(7'd1);
		issue(FN_INSERT, 16'h0005, 6'd0);
		issue(FN_READ, 16'h0000, 6'd1);
		issue(FN_REMOVE, 16'hFFFF, 6'd0);
		issue(FN_INSERT, 16'h0007, 6'd0);
		issue(FN_REMOVE, 16'h0000, 6'd0);
		issue(FN_INSERT, 16'h0007, 6'd0);
		write_capacity(7'd0);
		issue(FN_INSERT, 16'h0001, 6'd0);

		for (p = 0; p < NUM_PHASES; p++) begin
			write_capacity(CAP_W'(phase_cap[p]));
			pct = (p < 4) ? 24 : ((p < 8) ? 82 : 0);
			for (n = 0; n < phase_len[p]; n++) begin
				sender_gap(pct);
				r = $urandom_range(0, 99);
				v = pick_value();
				idx = INDEX_W'($urandom);
				if (r < phase_ins[p]) begin
					f = FN_INSERT;
				end else if (r < phase_ins[p] + phase_rem[p]) begin
					f = FN_REMOVE;
					if (sb.count > 0 && $urandom_range(0, 9) < 7)
						v = sb.entries[$urandom_range(0, sb.count - 1)];
				end else if (r < 96) begin
					f = FN_READ;
					if (sb.count > 0 && $urandom_range(0, 9) < 7)
						idx = INDEX_W'($urandom_range(0, sb.count - 1));
				end else begin
					f = FN_UNUSED;
				end
				issue(f, v, idx);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outcomes.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== sorted_table_insert_remove.f =====
sv/sti_pkg.sv
sv/sti_dpath.sv
sv/sti_ctrl.sv
sv/sorted_table_insert_remove.sv
verif/tb_sorted_table_insert_remove.sv
